// ===== src/affine_matrix_inverse_defines.svh =====
// assertion macros for the affine matrix inverse checker
// used by aim_checker only, needs aclk and aresetn in scope
`ifndef AFFINE_MATRIX_INVERSE_DEFINES_SVH
`define AFFINE_MATRIX_INVERSE_DEFINES_SVH

// same-cycle implication
`define AIM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aim_pkg.sv =====
// shared widths, microcode table and types for the affine matrix inverse
// used by aim_div and affine_matrix_inverse; no dependencies
package aim_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int ACC_W         = 100;          // holds det and translation numerators
    localparam int NUM_W         = 128;          // shifted dividend
    localparam int DIV_W         = ACC_W + 32;   // divisor shifted by the quotient width
    localparam int N_ELEM        = 12;
    localparam logic [3:0] LAST_IDX = 4'd11;
    localparam logic [5:0] NUM_UOPS = 6'd42;

    typedef struct packed {
        logic [3:0] ea0;      // element read port 0
        logic [3:0] ea1;      // element read port 1
        logic [3:0] ca;       // cofactor read address
        logic       use_coef; // multiplicand from cofactor memory
        logic       hi;       // upper partial product, weight 2^32
        logic       clr;      // start a new sum
        logic       neg;      // subtract the product
        logic       wr;       // write the sum to cofactor memory
        logic [3:0] wa;
    } uop_t;

    localparam logic [3:0] COF_K [9] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10};
    localparam logic [3:0] COF_A [9] = '{4'd5, 4'd9, 4'd1, 4'd8, 4'd0, 4'd4, 4'd4, 4'd8, 4'd0};
    localparam logic [3:0] COF_B [9] = '{4'd10, 4'd2, 4'd6, 4'd6, 4'd10, 4'd2, 4'd9, 4'd1, 4'd5};
    localparam logic [3:0] COF_C [9] = '{4'd9, 4'd1, 4'd5, 4'd4, 4'd8, 4'd0, 4'd8, 4'd0, 4'd4};
    localparam logic [3:0] COF_D [9] = '{4'd6, 4'd10, 4'd2, 4'd10, 4'd2, 4'd6, 4'd5, 4'd9, 4'd1};
    localparam logic [3:0] TRANS_E [3] = '{4'd3, 4'd7, 4'd11};

    // steps 0..17 cofactors, 18..35 translation numerators, 36..41 determinant
    function automatic uop_t uop_at(input logic [5:0] s);
        uop_t       u;
        logic [5:0] t;
        logic [3:0] n;
        logic [1:0] r;
        logic [2:0] m;
        u = '0;
        t = '0;
        n = '0;
        r = '0;
        m = '0;
        if (s < 6'd18) begin
            n     = 4'(s >> 1);
            u.clr = !s[0];
            u.neg = s[0];
            u.wr  = s[0];
            u.ea0 = s[0] ? COF_C[n] : COF_A[n];
            u.ea1 = s[0] ? COF_D[n] : COF_B[n];
            u.wa  = COF_K[n];
        end else if (s < 6'd36) begin
            t = s - 6'd18;
            r = (t >= 6'd12) ? 2'd2 : ((t >= 6'd6) ? 2'd1 : 2'd0);
            m = 3'(t - 6'(r) * 6'd6);
            u.use_coef = 1'b1;
            u.hi  = m[0];
            u.ca  = {r, 2'b00} + {2'b00, m[2:1]};
            u.ea1 = TRANS_E[m[2:1]];
            u.clr = (m == 3'd0);
            u.neg = 1'b1;
            u.wr  = (m == 3'd5);
            u.wa  = {r, 2'b11};
        end else begin
            t = s - 6'd36;
            u.use_coef = 1'b1;
            u.hi  = t[0];
            u.ca  = {t[2:1], 2'b00};
            u.ea1 = {2'b00, t[2:1]};
            u.clr = (t == 6'd0);
        end
        return u;
    endfunction

endpackage

// ===== src/aim_div.sv =====
// signed quotient unit, one quotient bit per cycle, truncating and saturating to 32 bits
// depends on aim_pkg
module aim_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [aim_pkg::NUM_W-1:0] num,
    input  logic signed [aim_pkg::ACC_W-1:0] den,
    output logic                           done,
    output logic [31:0]                    quot
);

    logic [aim_pkg::NUM_W-1:0] nmag;
    logic [aim_pkg::ACC_W-1:0] dmag;
    logic [aim_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [aim_pkg::DIV_W-1:0] dsh_reg, dsh_next;
    logic [31:0]               q_reg, q_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic                      neg_reg, neg_next;
    logic                      ovf_reg, ovf_next;

    assign nmag = num[aim_pkg::NUM_W-1] ? aim_pkg::NUM_W'(-num) : aim_pkg::NUM_W'(num);
    assign dmag = den[aim_pkg::ACC_W-1] ? aim_pkg::ACC_W'(-den) : aim_pkg::ACC_W'(den);

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            rem_next  = aim_pkg::DIV_W'(nmag);
            dsh_next  = aim_pkg::DIV_W'(dmag) << 31;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            neg_next  = num[aim_pkg::NUM_W-1] ^ den[aim_pkg::ACC_W-1];
            // quotient of 2^32 or more saturates whatever the sign
            ovf_next  = aim_pkg::DIV_W'(nmag) >= (aim_pkg::DIV_W'(dmag) << 32);
        end else if (busy_reg) begin
            if (rem_reg >= dsh_reg) begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                q_next   = {q_reg[30:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
    end

    always_comb begin
        if (ovf_reg) begin
            quot = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else if (neg_reg) begin
            quot = (q_reg[31] && (|q_reg[30:0])) ? 32'h8000_0000 : (32'd0 - q_reg);
        end else begin
            quot = q_reg[31] ? 32'h7fff_ffff : q_reg;
        end
    end

    assign done = done_reg;

endmodule

// ===== src/affine_matrix_inverse.sv =====
// Affine 3x4 matrix inverse, signed Q(31-F).F elements, loaded row-major one per
// transaction. Loading element 11 starts the inversion; the block then takes no
// input until all 12 inverse elements have left. Elements sit in a 12-entry store
// with two registered read ports; 2x2 cofactors, translation numerators and the
// determinant come from 42 microcoded multiply steps on one 33x32 multiplier,
// each passing through read, multiply and accumulate states, into a cofactor
// memory. Each output then goes through the bit-serial divider, which a singular
// matrix skips for an identity output. Indexes 12..15 are dropped.
module affine_matrix_inverse #(
    parameter int FRAC_BITS = aim_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] elem_index, [35:4] elem_value, [39:36] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] out_index, [35:4] out_value, [39:36] zero
    output logic        m_tuser,   // singular
    output logic        m_tlast    // last_elem
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RD   = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_ACC  = 8'b0000_1000,
        ST_DRD  = 8'b0001_0000,
        ST_DST  = 8'b0010_0000,
        ST_DWT  = 8'b0100_0000,
        ST_SEND = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  in_idx;
    logic [31:0] in_val;
    logic        in_acc;

    // element store and its valid bits
    logic [31:0]              emem [0:aim_pkg::N_ELEM-1];
    logic [aim_pkg::N_ELEM-1:0] evalid_reg;
    logic [31:0]              e0_q, e1_q;
    logic                     e0v_q, e1v_q;
    logic signed [31:0]       e0, e1;

    // cofactor memory
    logic [aim_pkg::ACC_W-1:0] cmem [0:aim_pkg::N_ELEM-1];
    logic [aim_pkg::ACC_W-1:0] c_q;
    logic [3:0]                c_addr;

    aim_pkg::uop_t uop;
    logic [5:0]  step_reg, step_next;
    logic [3:0]  k_reg, k_next;

    logic signed [32:0] mul_a;
    logic signed [64:0] prod_reg;
    logic signed [aim_pkg::ACC_W-1:0] term, acc_reg, acc_next, det_reg;
    logic        sing_reg;
    logic [31:0] val_reg, val_next;
    logic        val_load;

    logic signed [aim_pkg::NUM_W-1:0] dnum;
    logic        div_start, div_done;
    logic [31:0] div_quot;
    logic [31:0] ident;

    assign in_idx   = s_tdata[3:0];
    assign in_val   = s_tdata[35:4];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign uop      = aim_pkg::uop_at(step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evalid_reg <= '0;
        end else if (in_acc && in_idx <= aim_pkg::LAST_IDX) begin
            evalid_reg[in_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && in_idx <= aim_pkg::LAST_IDX) begin
            emem[in_idx] <= in_val;
        end
        e0_q  <= emem[uop.ea0];
        e1_q  <= emem[uop.ea1];
        e0v_q <= evalid_reg[uop.ea0];
        e1v_q <= evalid_reg[uop.ea1];
    end

    // never-loaded elements read as zero
    assign e0 = e0v_q ? signed'(e0_q) : 32'sd0;
    assign e1 = e1v_q ? signed'(e1_q) : 32'sd0;

    assign c_addr = state_reg[4] ? k_reg : uop.ca;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACC && uop.wr) begin
            cmem[uop.wa] <= acc_next;
        end
        c_q <= cmem[c_addr];
    end

    always_comb begin
        if (!uop.use_coef) begin
            mul_a = 33'(e0);
        end else if (uop.hi) begin
            mul_a = signed'(c_q[64:32]);
        end else begin
            mul_a = signed'({1'b0, c_q[31:0]});
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * e1;
    end

    always_comb begin
        term = aim_pkg::ACC_W'(prod_reg);
        if (uop.hi) begin
            term = term <<< 32;
        end
        acc_next = (uop.clr ? '0 : acc_reg) + (uop.neg ? -term : term);
    end

    // linear entries carry 2F fraction bits, the translation column 3F
    always_comb begin
        if (k_reg[1:0] == 2'b11) begin
            dnum = aim_pkg::NUM_W'(signed'(c_q)) <<< FRAC_BITS;
        end else begin
            dnum = aim_pkg::NUM_W'(signed'(c_q)) <<< (2 * FRAC_BITS);
        end
    end

    assign ident = (k_reg == 4'd0 || k_reg == 4'd5 || k_reg == 4'd10)
                   ? (32'd1 << FRAC_BITS) : 32'd0;

    aim_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (dnum),
        .den     (det_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        div_start  = 1'b0;
        val_load   = 1'b0;
        val_next   = val_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && in_idx == aim_pkg::LAST_IDX) begin
                    step_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:  state_next = ST_MUL;
            ST_MUL: state_next = ST_ACC;
            ST_ACC: begin
                if (step_reg == aim_pkg::NUM_UOPS - 6'd1) begin
                    k_next     = '0;
                    state_next = ST_DRD;
                end else begin
                    step_next  = step_reg + 6'd1;
                    state_next = ST_RD;
                end
            end
            ST_DRD: state_next = ST_DST;
            ST_DST: begin
                if (sing_reg) begin
                    val_load   = 1'b1;
                    val_next   = ident;
                    state_next = ST_SEND;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DWT;
                end
            end
            ST_DWT: begin
                if (div_done) begin
                    val_load   = 1'b1;
                    val_next   = div_quot;
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (m_tready) begin
                    if (k_reg == aim_pkg::LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_DRD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            k_reg     <= k_next;
        end
        if (state_reg == ST_ACC) begin
            acc_reg <= acc_next;
            if (step_reg == aim_pkg::NUM_UOPS - 6'd1) begin
                det_reg  <= acc_next;
                sing_reg <= (acc_next == '0);
            end
        end
        if (val_load) begin
            val_reg <= val_next;
        end
    end

    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = {4'd0, val_reg, k_reg};
    assign m_tuser  = sing_reg;
    assign m_tlast  = (k_reg == aim_pkg::LAST_IDX);

endmodule

// ===== src/aim_checker.sv =====
// port-level checks for affine_matrix_inverse, bound to the top level
// depends on affine_matrix_inverse_defines.svh
`include "affine_matrix_inverse_defines.svh"

module aim_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled result transaction holds its contents
    `AIM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // no new element while an inverse is being sent
    `AIM_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input taken during output")

    // the last flag marks position eleven only
    `AIM_ASSERT_NOW(a_last, m_tvalid, m_tlast == (m_tdata[3:0] == 4'd11), "last flag misplaced")

    // after element eleven is taken the block stops accepting
    `AIM_ASSERT_NEXT(a_start, s_tvalid && s_tready && s_tdata[3:0] == 4'd11, !s_tready, "inversion did not start")

    // a singular matrix gives identity, so off-diagonal entry one is zero
    `AIM_ASSERT_NOW(a_ident, m_tvalid && m_tuser && m_tdata[3:0] == 4'd1, m_tdata[35:4] == 32'd0, "singular output not identity")

endmodule

bind affine_matrix_inverse aim_checker u_aim_checker (.*);
